// ----- hdl/cst_pkg.sv -----
package cst_pkg;

   // Default identifier size: the buffer keeps one character less than this.
   localparam int IDENT_SIZE_DEF = 12;

   // Widths of the result fields.
   localparam int TOKEN_W = 6;
   localparam int ERROR_W = 2;
   localparam int CHARS_LOW_W = 64;
   localparam int CHARS_HIGH_W = 24;
   localparam int CHARS_W = CHARS_LOW_W + CHARS_HIGH_W;
   localparam int LENGTH_W = 4;
   localparam int NUMBER_W = 31;
   localparam int MAX_CHARS = CHARS_W / 8;
   localparam logic [NUMBER_W-1:0] NUMBER_MAX = '1;

   // Token codes.
   localparam logic [TOKEN_W-1:0] TOK_NOT      = 6'd0;
   localparam logic [TOKEN_W-1:0] TOK_NOTEQ    = 6'd1;
   localparam logic [TOKEN_W-1:0] TOK_IDENT    = 6'd2;
   localparam logic [TOKEN_W-1:0] TOK_NUMBER   = 6'd3;
   localparam logic [TOKEN_W-1:0] TOK_AND      = 6'd4;
   localparam logic [TOKEN_W-1:0] TOK_LPAREN   = 6'd5;
   localparam logic [TOKEN_W-1:0] TOK_RPAREN   = 6'd6;
   localparam logic [TOKEN_W-1:0] TOK_MUL      = 6'd7;
   localparam logic [TOKEN_W-1:0] TOK_PLUS     = 6'd8;
   localparam logic [TOKEN_W-1:0] TOK_COMMA    = 6'd9;
   localparam logic [TOKEN_W-1:0] TOK_MINUS    = 6'd10;
   localparam logic [TOKEN_W-1:0] TOK_DIV      = 6'd11;
   localparam logic [TOKEN_W-1:0] TOK_SEMI     = 6'd12;
   localparam logic [TOKEN_W-1:0] TOK_LESS     = 6'd13;
   localparam logic [TOKEN_W-1:0] TOK_LESSE    = 6'd14;
   localparam logic [TOKEN_W-1:0] TOK_ASSIGN   = 6'd15;
   localparam logic [TOKEN_W-1:0] TOK_EQUAL    = 6'd16;
   localparam logic [TOKEN_W-1:0] TOK_GREAT    = 6'd17;
   localparam logic [TOKEN_W-1:0] TOK_GREATE   = 6'd18;
   localparam logic [TOKEN_W-1:0] TOK_LBRACKET = 6'd19;
   localparam logic [TOKEN_W-1:0] TOK_RBRACKET = 6'd20;
   localparam logic [TOKEN_W-1:0] TOK_EOF      = 6'd21;
   localparam logic [TOKEN_W-1:0] TOK_CONST    = 6'd22;
   localparam logic [TOKEN_W-1:0] TOK_ELSE     = 6'd23;
   localparam logic [TOKEN_W-1:0] TOK_IF       = 6'd24;
   localparam logic [TOKEN_W-1:0] TOK_INT      = 6'd25;
   localparam logic [TOKEN_W-1:0] TOK_RETURN   = 6'd26;
   localparam logic [TOKEN_W-1:0] TOK_VOID     = 6'd27;
   localparam logic [TOKEN_W-1:0] TOK_WHILE    = 6'd28;
   localparam logic [TOKEN_W-1:0] TOK_LBRACE   = 6'd29;
   localparam logic [TOKEN_W-1:0] TOK_OR       = 6'd30;
   localparam logic [TOKEN_W-1:0] TOK_RBRACE   = 6'd31;
   localparam logic [TOKEN_W-1:0] TOK_ERRONLY  = 6'd32;

   // Error codes.
   localparam logic [ERROR_W-1:0] ERR_NONE      = 2'd0;
   localparam logic [ERROR_W-1:0] ERR_TOO_LONG  = 2'd1;
   localparam logic [ERROR_W-1:0] ERR_LONE_AMP  = 2'd2;
   localparam logic [ERROR_W-1:0] ERR_LONE_BAR  = 2'd3;

   // Keyword table, characters packed first character in the low byte.
   localparam int KW_COUNT = 7;
   localparam logic [CHARS_LOW_W-1:0] KW_TEXT [KW_COUNT] = '{
      64'h0000_0074_736e_6f63,   // const
      64'h0000_0000_6573_6c65,   // else
      64'h0000_0000_0000_6669,   // if
      64'h0000_0000_0074_6e69,   // int
      64'h0000_6e72_7574_6572,   // return
      64'h0000_0000_6469_6f76,   // void
      64'h0000_0065_6c69_6877    // while
   };
   localparam logic [LENGTH_W-1:0] KW_LEN [KW_COUNT] = '{
      4'd5, 4'd4, 4'd2, 4'd3, 4'd6, 4'd4, 4'd5
   };
   localparam logic [TOKEN_W-1:0] KW_CODE [KW_COUNT] = '{
      TOK_CONST, TOK_ELSE, TOK_IF, TOK_INT, TOK_RETURN, TOK_VOID, TOK_WHILE
   };

   // One result item.
   typedef struct packed {
      logic [TOKEN_W-1:0]      token_code;
      logic [ERROR_W-1:0]      error_code;
      logic [CHARS_LOW_W-1:0]  ident_chars_low;
      logic [CHARS_HIGH_W-1:0] ident_chars_high;
      logic [LENGTH_W-1:0]     ident_length;
      logic [NUMBER_W-1:0]     number_value;
      logic                    last_of_run;
   } rsp_item_type;

   // What one scanned input item produces: up to two result items.
   typedef struct packed {
      rsp_item_type first;
      rsp_item_type second;
      logic [1:0]   count;
   } lex_result_type;

   // Status of the result queue.
   typedef struct packed {
      logic [2:0] fill;
      logic       room;
   } queue_status_type;

   // Looks up a zero-padded identifier among the keywords; gives ident if none.
   function automatic logic [TOKEN_W-1:0] kw_lookup(input logic [CHARS_LOW_W-1:0] chars,
                                                    input logic [LENGTH_W-1:0] len);
      logic [TOKEN_W-1:0] code;
      code = TOK_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (chars == KW_TEXT[k] && len == KW_LEN[k]) begin
            code = KW_CODE[k];
         end
      end
      return code;
   endfunction

   // A result item with no identifier and no number.
   function automatic rsp_item_type plain_item(input logic [TOKEN_W-1:0] code,
                                               input logic [ERROR_W-1:0] err);
      rsp_item_type item;
      item = '0;
      item.token_code = code;
      item.error_code = err;
      return item;
   endfunction

endpackage

// ----- hdl/cst_lex_core.sv -----
module cst_lex_core
   import cst_pkg::*;
#(
   parameter int IDENT_SIZE = IDENT_SIZE_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step_valid,
   input  logic [7:0]     step_byte,
   input  logic           step_eoi,
   output lex_result_type result
);

   localparam int BufDepth = IDENT_SIZE - 1;
   localparam logic [LENGTH_W-1:0] IdentLimit = LENGTH_W'(BufDepth);

   // Pending lexeme kinds.
   localparam logic [3:0] M_IDLE   = 4'd0;
   localparam logic [3:0] M_IDENT  = 4'd1;
   localparam logic [3:0] M_NUMBER = 4'd2;
   localparam logic [3:0] M_BANG   = 4'd3;
   localparam logic [3:0] M_AMP    = 4'd4;
   localparam logic [3:0] M_LESS   = 4'd5;
   localparam logic [3:0] M_EQ     = 4'd6;
   localparam logic [3:0] M_GREAT  = 4'd7;
   localparam logic [3:0] M_BAR    = 4'd8;

   logic [3:0]          mode_ff, mode_in;
   logic [LENGTH_W-1:0] count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic [NUMBER_W-1:0] acc_ff, acc_in;
   logic [7:0]          buf_ff [BufDepth];

   logic                buf_we;
   logic [LENGTH_W-1:0] buf_idx;
   logic [CHARS_W-1:0]  chars;
   logic [TOKEN_W-1:0]  kw_code;
   rsp_item_type        flush_item;
   logic [34:0]         acc_x10;
   logic [NUMBER_W-1:0] acc_next;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // Identifier characters kept so far, zero beyond the count.
   for (genvar i = 0; i < MAX_CHARS; i++) begin : g_chars
      if (i < BufDepth) begin : g_kept
         assign chars[8*i +: 8] = (LENGTH_W'(i) < count_ff) ? buf_ff[i] : 8'h00;
      end else begin : g_none
         assign chars[8*i +: 8] = 8'h00;
      end
   end

   assign kw_code = kw_lookup(chars[CHARS_LOW_W-1:0], count_ff);

   // Decimal accumulate with saturation.
   assign acc_x10 = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                  + {27'b0, step_byte - 8'h30};
   assign acc_next = (acc_x10 > {4'b0, NUMBER_MAX}) ? NUMBER_MAX : acc_x10[NUMBER_W-1:0];

   // Short form of the pending lexeme.
   always_comb begin
      case (mode_ff)
         M_IDENT: begin
            if (!ovf_ff && kw_code != TOK_IDENT) begin
               flush_item = plain_item(kw_code, ERR_NONE);
            end else begin
               flush_item = plain_item(TOK_IDENT, ovf_ff ? ERR_TOO_LONG : ERR_NONE);
               flush_item.ident_chars_low = chars[CHARS_LOW_W-1:0];
               flush_item.ident_chars_high = chars[CHARS_W-1:CHARS_LOW_W];
               flush_item.ident_length = count_ff;
            end
         end
         M_NUMBER: begin
            flush_item = plain_item(TOK_NUMBER, ERR_NONE);
            flush_item.number_value = acc_ff;
         end
         M_BANG:  flush_item = plain_item(TOK_NOT, ERR_NONE);
         M_AMP:   flush_item = plain_item(TOK_ERRONLY, ERR_LONE_AMP);
         M_LESS:  flush_item = plain_item(TOK_LESS, ERR_NONE);
         M_EQ:    flush_item = plain_item(TOK_ASSIGN, ERR_NONE);
         M_GREAT: flush_item = plain_item(TOK_GREAT, ERR_NONE);
         M_BAR:   flush_item = plain_item(TOK_ERRONLY, ERR_LONE_BAR);
         default: flush_item = plain_item(TOK_ERRONLY, ERR_NONE);
      endcase
   end

   // One step of the scanner: continue, close or start a lexeme.
   always_comb begin
      logic                scan_emit;
      logic [TOKEN_W-1:0]  scan_code;
      logic [3:0]          scan_mode;
      logic                pair_hit;
      logic                rescan;
      logic [TOKEN_W-1:0]  two_code;
      rsp_item_type        scan_item;

      scan_emit = 1'b0;
      scan_code = TOK_ERRONLY;
      scan_mode = M_IDLE;
      pair_hit  = 1'b0;
      rescan    = 1'b0;
      two_code  = TOK_ERRONLY;
      mode_in   = mode_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      acc_in    = acc_ff;
      buf_we    = 1'b0;
      buf_idx   = count_ff;
      result    = '0;

      // Fresh scan of the byte, as if no lexeme were pending.
      if (is_alpha(step_byte)) begin
         scan_mode = M_IDENT;
      end else if (is_digit(step_byte)) begin
         if (step_byte == "0") begin
            scan_emit = 1'b1;
            scan_code = TOK_NUMBER;
         end else begin
            scan_mode = M_NUMBER;
         end
      end else begin
         case (step_byte)
            "!": scan_mode = M_BANG;
            "&": scan_mode = M_AMP;
            "<": scan_mode = M_LESS;
            "=": scan_mode = M_EQ;
            ">": scan_mode = M_GREAT;
            "|": scan_mode = M_BAR;
            "/": begin scan_emit = 1'b1; scan_code = TOK_DIV; end
            "*": begin scan_emit = 1'b1; scan_code = TOK_MUL; end
            "+": begin scan_emit = 1'b1; scan_code = TOK_PLUS; end
            "-": begin scan_emit = 1'b1; scan_code = TOK_MINUS; end
            "(": begin scan_emit = 1'b1; scan_code = TOK_LPAREN; end
            ")": begin scan_emit = 1'b1; scan_code = TOK_RPAREN; end
            ",": begin scan_emit = 1'b1; scan_code = TOK_COMMA; end
            ";": begin scan_emit = 1'b1; scan_code = TOK_SEMI; end
            "[": begin scan_emit = 1'b1; scan_code = TOK_LBRACKET; end
            "]": begin scan_emit = 1'b1; scan_code = TOK_RBRACKET; end
            "{": begin scan_emit = 1'b1; scan_code = TOK_LBRACE; end
            "}": begin scan_emit = 1'b1; scan_code = TOK_RBRACE; end
            default: scan_emit = 1'b0;
         endcase
      end
      scan_item = plain_item(scan_code, ERR_NONE);

      // Second character of the two-character operators.
      case (mode_ff)
         M_BANG:  begin pair_hit = step_byte == "="; two_code = TOK_NOTEQ; end
         M_AMP:   begin pair_hit = step_byte == "&"; two_code = TOK_AND; end
         M_LESS:  begin pair_hit = step_byte == "="; two_code = TOK_LESSE; end
         M_EQ:    begin pair_hit = step_byte == "="; two_code = TOK_EQUAL; end
         M_GREAT: begin pair_hit = step_byte == "="; two_code = TOK_GREATE; end
         M_BAR:   begin pair_hit = step_byte == "|"; two_code = TOK_OR; end
         default: pair_hit = 1'b0;
      endcase

      if (step_eoi) begin
         // End of input: flush the pending lexeme, then eof.
         mode_in = M_IDLE;
         if (mode_ff != M_IDLE) begin
            result.first = flush_item;
            result.second = plain_item(TOK_EOF, ERR_NONE);
            result.count = 2'd2;
         end else begin
            result.first = plain_item(TOK_EOF, ERR_NONE);
            result.count = 2'd1;
         end
      end else if (mode_ff == M_IDENT && (is_alpha(step_byte) || is_digit(step_byte))) begin
         // Identifier grows, or overflows once the buffer is full.
         if (count_ff < IdentLimit) begin
            buf_we = 1'b1;
            count_in = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end else if (mode_ff == M_NUMBER && is_digit(step_byte)) begin
         acc_in = acc_next;
      end else if (pair_hit) begin
         result.first = plain_item(two_code, ERR_NONE);
         result.count = 2'd1;
         mode_in = M_IDLE;
      end else begin
         // Close any pending lexeme and scan the byte afresh.
         rescan = 1'b1;
         if (mode_ff != M_IDLE) begin
            result.first = flush_item;
            result.second = scan_item;
            result.count = scan_emit ? 2'd2 : 2'd1;
         end else begin
            result.first = scan_item;
            result.count = scan_emit ? 2'd1 : 2'd0;
         end
      end

      // Side effects of starting a lexeme.
      if (rescan) begin
         mode_in = scan_mode;
         if (scan_mode == M_IDENT) begin
            buf_we = 1'b1;
            buf_idx = '0;
            count_in = LENGTH_W'(1);
            ovf_in = 1'b0;
         end
         if (scan_mode == M_NUMBER) begin
            acc_in = {23'b0, step_byte - 8'h30};
         end
      end

      // Mark the final result of this item.
      if (result.count == 2'd2) begin
         result.second.last_of_run = 1'b1;
      end else if (result.count == 2'd1) begin
         result.first.last_of_run = 1'b1;
      end
   end

   // Lexeme state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         acc_ff   <= '0;
      end else if (step_valid) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         acc_ff   <= acc_in;
      end
   end

   // Identifier buffer, written at the current character count.
   always_ff @(posedge clock) begin
      for (int i = 0; i < BufDepth; i++) begin
         if (step_valid && buf_we && buf_idx == LENGTH_W'(i)) begin
            buf_ff[i] <= step_byte;
         end
      end
   end

endmodule

// ----- hdl/cst_rsp_queue.sv -----
module cst_rsp_queue
   import cst_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  lex_result_type   push,
   input  logic             pop_ready,
   output logic             pop_valid,
   output rsp_item_type     pop_item,
   output queue_status_type status
);

   localparam int Depth = 4;

   rsp_item_type entry_ff [Depth];
   logic [1:0]   wr_ptr_ff, wr_ptr_in;
   logic [1:0]   rd_ptr_ff, rd_ptr_in;
   logic [2:0]   fill_ff, fill_in;
   logic [1:0]   push_count;
   logic         pop_fire;

   assign push_count = push_valid ? push.count : 2'd0;
   assign pop_valid  = fill_ff != 3'd0;
   assign pop_fire   = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   // Room for the two results that one item may cause.
   assign status.fill = fill_ff;
   assign status.room = fill_ff <= 3'(Depth - 2);

   assign wr_ptr_in = wr_ptr_ff + push_count;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop_fire};
   assign fill_in   = fill_ff + {1'b0, push_count} - {2'b0, pop_fire};

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage: the first result at the write pointer, the second after it.
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push.second;
      end
   end

endmodule

// ----- hdl/c_subset_token_scanner.sv -----
// Token scanner for a small C subset.
// The request channel carries one source byte per item in req_tdata; an item
// with req_tlast high marks end of input, flushes any pending lexeme and gives
// an eof token (its data byte is ignored). The response channel carries one
// token per item: token and error codes in rsp_tuser, identifier text, length
// and number value in rsp_tdata, and rsp_tlast on the final token that one
// request item causes. A request item gives zero, one or two tokens.
// Throughput is one request item per cycle while each item gives at most one
// token and the receiver keeps up; the input register and a four-entry
// response queue part the two sides.
// The first token of an item passes through the input register and then a queue
// entry before it shows on the response channel, where it can be taken.
// When the receiver stalls, the queue fills; once fewer than two free entries
// remain, the input register keeps its item and req_tready stays low until
// room frees up, so no item is lost.
// Synchronous reset returns the scanner to its idle state with no pending
// lexeme and empties the queue; identifier storage is not cleared.
module c_subset_token_scanner
   import cst_pkg::*;
#(
   parameter int IDENT_SIZE = IDENT_SIZE_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // char_byte
   input  logic         req_tlast,   // end_of_input
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // ident_chars_low, ident_chars_high, ident_length, number_value, zero fill
   output logic [127:0] rsp_tdata,
   output logic [7:0]   rsp_tuser,   // token_code, error_code
   output logic         rsp_tlast    // last_of_run
);

   logic             in_valid_ff;
   logic [7:0]       byte_ff;
   logic             eoi_ff;
   logic             step_fire;
   lex_result_type   lex_result;
   rsp_item_type     rsp_item;
   queue_status_type q_status;

   // Input register: refilled when empty or when its item is scanned.
   assign step_fire  = in_valid_ff && q_status.room;
   assign req_tready = !in_valid_ff || step_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         byte_ff <= req_tdata;
         eoi_ff  <= req_tlast;
      end
   end

   cst_lex_core #(
      .IDENT_SIZE(IDENT_SIZE)
   ) u_lex_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step_fire),
      .step_byte  (byte_ff),
      .step_eoi   (eoi_ff),
      .result     (lex_result)
   );

   cst_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (step_fire),
      .push       (lex_result),
      .pop_ready  (rsp_tready),
      .pop_valid  (rsp_tvalid),
      .pop_item   (rsp_item),
      .status     (q_status)
   );

   // Response packing.
   assign rsp_tdata = {5'b0, rsp_item.number_value, rsp_item.ident_length,
                       rsp_item.ident_chars_high, rsp_item.ident_chars_low};
   assign rsp_tuser = {rsp_item.error_code, rsp_item.token_code};
   assign rsp_tlast = rsp_item.last_of_run;

`ifndef SYNTHESIS
   // The queue never holds more than its four entries.
   assert property (@(posedge clock) disable iff (reset) q_status.fill <= 3'd4)
      else $error("response queue overfilled");

   // End of input always gives eof as the final token of the item.
   assert property (@(posedge clock) disable iff (reset)
      step_fire && eoi_ff |->
         (lex_result.count == 2'd1 && lex_result.first.token_code == TOK_EOF) ||
         (lex_result.count == 2'd2 && lex_result.second.token_code == TOK_EOF))
      else $error("end of input without eof token");

   // A scanned item is only taken when two free entries are left.
   assert property (@(posedge clock) disable iff (reset)
      step_fire |=> q_status.fill <= 3'd4 && $past(q_status.fill) <= 3'd2)
      else $error("item scanned without queue room");
`endif

endmodule
